/* hw/rtl/jit_pkg.sv */
// Shared types and constants of the job id table.
// No dependencies; imported by every module of the block.
package jit_pkg;

   // Default sizes
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_JOB_ID_DEF  = 16;

   // Field widths
   localparam int PID_W = 22;
   localparam int JID_W = 5;
   localparam int RS_W  = 2;
   localparam int OP_W  = 3;

   // Request codes
   localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP_PID = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP_JID = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND_FG    = 3'd4;

   // Run states
   localparam logic [RS_W-1:0] RS_FOREGROUND = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0]  req_type;
      logic [PID_W-1:0] proc_id;
      logic [JID_W-1:0] job_number;
      logic [RS_W-1:0]  run_state;
   } jit_req_type;

   typedef struct packed {
      logic             hit;
      logic [PID_W-1:0] out_proc_id;
      logic [JID_W-1:0] out_job_number;
      logic [RS_W-1:0]  out_run_state;
   } jit_rsp_type;

   // One table entry; a zero process id marks a free slot
   typedef struct packed {
      logic [PID_W-1:0] proc_id;
      logic [JID_W-1:0] job_number;
      logic [RS_W-1:0]  run_state;
   } jit_entry_type;

endpackage

/* hw/rtl/jit_cell.sv */
// One slot of the table ring: holds an entry and passes it on when shifting.
// Depends on jit_pkg.
module jit_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  jit_pkg::jit_entry_type entry_d,
   output jit_pkg::jit_entry_type entry_q
);
   import jit_pkg::*;

   jit_entry_type entry_ff;
   jit_entry_type entry_in;

   // take the neighbour's entry while the ring turns
   assign entry_in = shift_en ? entry_d : entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_q = entry_ff;

endmodule

/* hw/rtl/jit_ctrl.sv */
// Walk sequencer: turns the slot ring once per item, examines the head slot,
// rewrites it on add or delete, tracks the largest live job id and the next id.
// Depends on jit_pkg.
module jit_ctrl #(
   parameter int TABLE_DEPTH = jit_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_JOB_ID  = jit_pkg::MAX_JOB_ID_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  jit_pkg::jit_req_type   req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output jit_pkg::jit_rsp_type   rsp_data,
   input  jit_pkg::jit_entry_type head,
   output jit_pkg::jit_entry_type wb,
   output logic                   shift_en
);
   import jit_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NEXT_W = $clog2(MAX_JOB_ID + 1);
   localparam int CMP_W  = ((NEXT_W > JID_W) ? NEXT_W : JID_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_JOB_ID);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   jit_req_type       req_ff, req_in;
   logic              found_ff, found_in;
   jit_entry_type     match_ff, match_in;
   logic [JID_W-1:0]  max_ff, max_in;
   logic [NEXT_W-1:0] next_ff, next_in;
   logic              rsp_valid_ff, rsp_valid_in;
   jit_rsp_type       rsp_ff, rsp_in;

   logic [CMP_W-1:0]  next_ext;
   logic [CMP_W-1:0]  add_sum;
   logic [CMP_W-1:0]  del_sum;
   logic              pid_ok;
   logic              pid_eq;
   jit_entry_type     new_entry;

   assign next_ext = CMP_W'(next_ff);
   assign add_sum  = next_ext + CMP_W'(1);
   assign del_sum  = CMP_W'(max_ff) + CMP_W'(1);
   assign pid_ok   = (req_ff.proc_id != '0);
   assign pid_eq   = pid_ok && (head.proc_id == req_ff.proc_id);

   // entry written by an add
   always_comb begin
      new_entry.proc_id    = req_ff.proc_id;
      new_entry.job_number = next_ext[JID_W-1:0];
      new_entry.run_state  = req_ff.run_state;
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      max_in       = max_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wb           = head;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               found_in = 1'b0;
               max_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // first match only; head entry is rewritten on add or delete
            if (!found_ff) begin
               unique case (req_ff.req_type)
                  OP_ADD: begin
                     if (pid_ok && head.proc_id == '0) begin
                        wb       = new_entry;
                        found_in = 1'b1;
                        match_in = new_entry;
                     end
                  end
                  OP_DELETE: begin
                     if (pid_eq) begin
                        wb       = '0;
                        found_in = 1'b1;
                        match_in = head;
                     end
                  end
                  OP_LOOKUP_PID: begin
                     if (pid_eq) begin
                        found_in = 1'b1;
                        match_in = head;
                     end
                  end
                  OP_LOOKUP_JID: begin
                     if (req_ff.job_number != '0 &&
                         head.job_number == req_ff.job_number) begin
                        found_in = 1'b1;
                        match_in = head;
                     end
                  end
                  OP_FIND_FG: begin
                     if (head.run_state == RS_FOREGROUND) begin
                        found_in = 1'b1;
                        match_in = head;
                     end
                  end
                  default: ;
               endcase
            end
            // largest job id left in the table after this pass
            if (wb.job_number > max_ff) begin
               max_in = wb.job_number;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_in.hit            = 1'b1;
                  rsp_in.out_proc_id    = match_ff.proc_id;
                  rsp_in.out_job_number = match_ff.job_number;
                  rsp_in.out_run_state  = match_ff.run_state;
               end else begin
                  rsp_in = '0;
               end
               if (found_ff && req_ff.req_type == OP_ADD) begin
                  next_in = (add_sum > MAX_EXT) ? NEXT_W'(1) : add_sum[NEXT_W-1:0];
               end else if (found_ff && req_ff.req_type == OP_DELETE) begin
                  next_in = (del_sum > MAX_EXT) ? NEXT_W'(1) : del_sum[NEXT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= 1'b0;
         next_ff      <= NEXT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      req_ff   <= req_in;
      match_ff <= match_in;
      max_ff   <= max_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign shift_en  = (state_ff == ST_WALK);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/job_id_table_core.sv */
// Job id table: a ring of TABLE_DEPTH slot cells turned once per item.
// A request is accepted in the idle state and walked once through every slot at the ring head;
// its result is then registered, and the next request is taken only once the block is idle again.
// A result held back by rsp_ready does not stop the next walk; that item waits in its result
// state until the output register frees.
// Reset: synchronous; all slots free, next job id 1, no result pending.
module job_id_table_core #(
   parameter int TABLE_DEPTH = jit_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_JOB_ID  = jit_pkg::MAX_JOB_ID_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jit_pkg::jit_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jit_pkg::jit_rsp_type rsp_data
);
   import jit_pkg::*;

   jit_entry_type cell_d [TABLE_DEPTH];
   jit_entry_type cell_q [TABLE_DEPTH];
   jit_entry_type wb;
   logic          shift_en;

   // slot ring: each cell takes its upper neighbour, the top takes the write-back
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == TABLE_DEPTH - 1) begin : g_top
         assign cell_d[i] = wb;
      end else begin : g_mid
         assign cell_d[i] = cell_q[i+1];
      end
      jit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .entry_d  (cell_d[i]),
         .entry_q  (cell_q[i])
      );
   end

   jit_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_JOB_ID  (MAX_JOB_ID)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .head      (cell_q[0]),
      .wb        (wb),
      .shift_en  (shift_en)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for job_id_table_core: a scoreboard class predicts every result.
// Depends on jit_pkg and job_id_table_core from hw/rtl.
module tb;
   import jit_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int RESET_LEN   = 10;
   localparam int RANDOM_ITEMS = 500;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 200000;

   // Codes the package does not name
   localparam logic [OP_W-1:0] OP_LAST_CODE  = '1;
   localparam logic [OP_W-1:0] OP_SPARE_LO   = OP_W'(OP_FIND_FG + 1);
   localparam logic [OP_W-1:0] OP_SPARE_MID  = OP_W'(OP_FIND_FG + 2);
   localparam logic [RS_W-1:0] RS_UNDEFINED  = 2'd0;
   localparam logic [RS_W-1:0] RS_BACKGROUND = 2'd2;
   localparam logic [RS_W-1:0] RS_STOPPED    = 2'd3;
   localparam logic [PID_W-1:0] PID_MAX      = '1;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED} op_mix_type;

   // Shadow job table; expected results kept in order of acceptance
   class scoreboard_type;
      jit_entry_type    slots[TABLE_DEPTH_DEF];
      int               next_jid;
      jit_rsp_type      expected_q[$];
      int               errors;

      function new();
         foreach (slots[i]) slots[i] = '0;
         next_jid = 1;
         errors   = 0;
      endfunction

      function void note_request(jit_req_type r);
         int          found;
         int          top_jid;
         jit_rsp_type res;
         found = -1;
         // slot search, lowest index first
         for (int i = 0; i < TABLE_DEPTH_DEF && found < 0; i++) begin
            case (r.req_type)
               OP_ADD:
                  if (r.proc_id != 0 && slots[i].proc_id == 0) found = i;
               OP_DELETE, OP_LOOKUP_PID:
                  if (r.proc_id != 0 && slots[i].proc_id == r.proc_id) found = i;
               OP_LOOKUP_JID:
                  if (r.job_number != 0 && slots[i].job_number == r.job_number) found = i;
               OP_FIND_FG:
                  if (slots[i].run_state == RS_FOREGROUND) found = i;
               default: ;
            endcase
         end
         // an add fills its slot before the result is formed
         if (r.req_type == OP_ADD && found >= 0) begin
            slots[found].proc_id    = r.proc_id;
            slots[found].job_number = next_jid[JID_W-1:0];
            slots[found].run_state  = r.run_state;
            next_jid = (next_jid + 1 > MAX_JOB_ID_DEF) ? 1 : next_jid + 1;
         end
         res = (found < 0) ? '0 : {1'b1, slots[found]};
         expected_q.push_back(res);
         // a delete reports the old entry, then frees it and recomputes the next id
         if (r.req_type == OP_DELETE && found >= 0) begin
            slots[found] = '0;
            top_jid = 0;
            foreach (slots[i])
               if (slots[i].job_number > top_jid) top_jid = slots[i].job_number;
            next_jid = (top_jid + 1 > MAX_JOB_ID_DEF) ? 1 : top_jid + 1;
         end
      endfunction

      function void check_response(jit_rsp_type got);
         jit_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            errors++;
         end
         if (got.out_proc_id !== want.out_proc_id) begin
            $error("out_proc_id: expected %h, got %h", want.out_proc_id, got.out_proc_id);
            errors++;
         end
         if (got.out_job_number !== want.out_job_number) begin
            $error("out_job_number: expected %0d, got %0d",
                   want.out_job_number, got.out_job_number);
            errors++;
         end
         if (got.out_run_state !== want.out_run_state) begin
            $error("out_run_state: expected %0d, got %0d",
                   want.out_run_state, got.out_run_state);
            errors++;
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   jit_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   jit_rsp_type rsp_data;

   scoreboard_type    job_table = new();
   logic [PID_W-1:0]  pid_pool[20];
   int                cycle_count = 0;

   job_id_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Handshake monitor: note requests, check results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) job_table.note_request(req_data);
         if (rsp_valid && rsp_ready) job_table.check_response(rsp_data);
      end
   end

   // Result side: random stalls, steady stretches, one long hold-off
   initial begin
      int wait_cycles;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (taken % 64 == 0) steady = ($urandom_range(0, 2) == 0);
         wait_cycles = steady ? 0 : $urandom_range(0, 15);
         if (taken == 40) wait_cycles = LONG_HOLD;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Offer one item, after an optional gap, and hold it until accepted
   task automatic send_request(input jit_req_type item, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic jit_req_type random_request(op_mix_type mix);
      jit_req_type r;
      int          roll;
      int          add_pct;
      int          del_pct;
      int          pick;
      case (mix)
         MIX_FILL:  begin add_pct = 70; del_pct = 10; end
         MIX_DRAIN: begin add_pct = 15; del_pct = 55; end
         default:   begin add_pct = 35; del_pct = 25; end
      endcase
      // pids mostly from a small pool so that hits and duplicates are common
      pick = $urandom_range(0, 99);
      if (pick < 5)       r.proc_id = '0;
      else if (pick < 15) r.proc_id = PID_W'($urandom_range(0, PID_MAX));
      else                r.proc_id = pid_pool[$urandom_range(0, 19)];
      r.job_number = ($urandom_range(0, 9) == 0) ? JID_W'($urandom_range(17, 31))
                                                : JID_W'($urandom_range(0, 17));
      r.run_state  = RS_W'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < add_pct)                r.req_type = OP_ADD;
      else if (roll < add_pct + del_pct) r.req_type = OP_DELETE;
      else begin
         pick = $urandom_range(0, 19);
         if (pick < 7)       r.req_type = OP_LOOKUP_PID;
         else if (pick < 13) r.req_type = OP_LOOKUP_JID;
         else if (pick < 18) r.req_type = OP_FIND_FG;
         else                r.req_type = OP_W'($urandom_range(OP_SPARE_LO, OP_LAST_CODE));
      end
      return r;
   endfunction

   // Stimulus: directed opening, then random rounds of fill, drain and mixed traffic
   initial begin
      jit_req_type directed[$];
      int          random_sent;
      int          round_len;
      op_mix_type  mix;
      bit          no_gaps;

      pid_pool[0] = PID_MAX;
      pid_pool[1] = 22'd1;
      pid_pool[2] = 22'h2AAAAA;
      pid_pool[3] = 22'h155555;
      for (int i = 4; i < 20; i++) pid_pool[i] = PID_W'($urandom_range(1, PID_MAX));

      // empty table, zero ids, extremes, duplicates, deletes to empty, unused codes
      directed = '{
         '{OP_FIND_FG,     22'd0,     5'd0,  RS_UNDEFINED},
         '{OP_LOOKUP_JID,  22'd0,     5'd0,  RS_UNDEFINED},
         '{OP_ADD,         22'd0,     5'd7,  RS_FOREGROUND},
         '{OP_ADD,         PID_MAX,   5'd31, RS_STOPPED},
         '{OP_ADD,         22'd1,     5'd0,  RS_UNDEFINED},
         '{OP_ADD,         22'h2AAAAA,5'd0,  RS_FOREGROUND},
         '{OP_ADD,         22'd1,     5'd0,  RS_BACKGROUND},
         '{OP_LOOKUP_PID,  22'd1,     5'd0,  RS_UNDEFINED},
         '{OP_LOOKUP_PID,  22'd0,     5'd3,  RS_UNDEFINED},
         '{OP_LOOKUP_PID,  PID_MAX,   5'd0,  RS_UNDEFINED},
         '{OP_LOOKUP_JID,  22'd1,     5'd3,  RS_UNDEFINED},
         '{OP_LOOKUP_JID,  PID_MAX,   5'd31, RS_STOPPED},
         '{OP_LOOKUP_JID,  22'd0,     5'd16, RS_UNDEFINED},
         '{OP_FIND_FG,     22'd0,     5'd0,  RS_UNDEFINED},
         '{OP_DELETE,      22'd0,     5'd0,  RS_UNDEFINED},
         '{OP_DELETE,      22'h155555,5'd0,  RS_UNDEFINED},
         '{OP_DELETE,      22'd1,     5'd0,  RS_UNDEFINED},
         '{OP_LOOKUP_PID,  22'd1,     5'd0,  RS_UNDEFINED},
         '{OP_DELETE,      22'h2AAAAA,5'd0,  RS_UNDEFINED},
         '{OP_FIND_FG,     22'd0,     5'd0,  RS_UNDEFINED},
         '{OP_SPARE_LO,    PID_MAX,   5'd31, RS_STOPPED},
         '{OP_SPARE_MID,   22'd1,     5'd1,  RS_FOREGROUND},
         '{OP_LAST_CODE,   22'h2AAAAA,5'd16, RS_BACKGROUND},
         '{OP_DELETE,      PID_MAX,   5'd0,  RS_UNDEFINED},
         '{OP_DELETE,      22'd1,     5'd0,  RS_UNDEFINED},
         '{OP_ADD,         22'h155555,5'd0,  RS_FOREGROUND}
      };

      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i], 1'($urandom_range(0, 1)));

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         round_len = $urandom_range(10, 40);
         mix       = op_mix_type'($urandom_range(0, 2));
         no_gaps   = ($urandom_range(0, 2) == 0);
         repeat (round_len) send_request(random_request(mix), no_gaps);
         random_sent += round_len;
      end
      req_valid <= 1'b0;

      // drain, then give a stray result time to show up
      while (job_table.expected_q.size() > 0) @(posedge clock);
      repeat (TABLE_DEPTH_DEF + 8) @(posedge clock);

      if (job_table.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
